/* rtl/core/fcg_pkg.sv */
`default_nettype none
package fcg_pkg;

  localparam int MAX_MAPS    = 8;
  localparam int TABLE_DEPTH = 4096;
  localparam int SIDX_W      = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int SCNT_W      = $clog2(MAX_MAPS + 1);
  localparam int TADDR_W     = $clog2(TABLE_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAPS_IN_USE = 2'd1;

  localparam logic [1:0] KIND_DESC   = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_SJIS   = 2'd1;
  localparam logic [1:0] MODE_TABLE  = 2'd2;
  localparam logic [1:0] MODE_PAIRS  = 2'd3;

  localparam logic [1:0] ASEL_BASE = 2'd0;
  localparam logic [1:0] ASEL_TAB  = 2'd1;
  localparam logic [1:0] ASEL_KEY  = 2'd2;
  localparam logic [1:0] ASEL_VAL  = 2'd3;

  localparam logic [2:0] GSEL_REPL   = 3'd0;
  localparam logic [2:0] GSEL_LINEAR = 3'd1;
  localparam logic [2:0] GSEL_SJ_FIX = 3'd2;
  localparam logic [2:0] GSEL_SJ_TAB = 3'd3;
  localparam logic [2:0] GSEL_MEM    = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [1:0]  map_mode;
    logic [15:0] first_code;
    logic [15:0] last_code;
    logic [11:0] entry_count;
    logic [11:0] table_base;
    logic [11:0] word_address;
    logic [15:0] word_value;
    logic [15:0] code;
  } in_word_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic        range_hit;
  } out_word_t;

  typedef struct packed {
    logic       desc_wr;
    logic       tab_wr;
    logic       lookup_start;
    logic       scan_next;
    logic       pair_init;
    logic       pair_probe;
    logic       pair_lt;
    logic       pair_gt;
    logic       mem_rd;
    logic [1:0] asel;
    logic       out_load;
    logic [2:0] gsel;
    logic       out_hit;
  } cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       in_range;
    logic [1:0] mode;
    logic       count_zero;
    logic       pair_empty;
    logic       key_eq;
    logic       key_lt;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/fcg_ctrl.sv */
`default_nettype none
module fcg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      kind,
  input  wire fcg_pkg::status_t st,
  output logic                 busy,
  output fcg_pkg::cmd_t        cmd
);
  import fcg_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SJ_RD    = 3'd2;
  localparam logic [2:0] S_MEM_OUT  = 3'd3;
  localparam logic [2:0] S_PAIR_CHK = 3'd4;
  localparam logic [2:0] S_PAIR_KEY = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_DESC: cmd.desc_wr = 1'b1;
            KIND_WORD: cmd.tab_wr = 1'b1;
            KIND_LOOKUP: begin
              cmd.lookup_start = 1'b1;
              state_nxt        = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (st.scan_end) begin
          cmd.out_load = 1'b1;
          cmd.gsel     = GSEL_REPL;
          state_nxt    = S_IDLE;
        end else if (!st.in_range) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.out_hit = 1'b1;
          case (st.mode)
            MODE_LINEAR: begin
              cmd.out_load = 1'b1;
              cmd.gsel     = GSEL_LINEAR;
              state_nxt    = S_IDLE;
            end
            MODE_SJIS: begin
              if (st.count_zero) begin
                cmd.out_load = 1'b1;
                cmd.gsel     = GSEL_SJ_FIX;
                state_nxt    = S_IDLE;
              end else begin
                cmd.mem_rd = 1'b1;
                cmd.asel   = ASEL_BASE;
                state_nxt  = S_SJ_RD;
              end
            end
            MODE_TABLE: begin
              cmd.mem_rd = 1'b1;
              cmd.asel   = ASEL_TAB;
              state_nxt  = S_MEM_OUT;
            end
            default: begin
              cmd.pair_init = 1'b1;
              state_nxt     = S_PAIR_CHK;
            end
          endcase
        end
      end
      S_SJ_RD: begin
        cmd.out_load = 1'b1;
        cmd.out_hit  = 1'b1;
        cmd.gsel     = GSEL_SJ_TAB;
        state_nxt    = S_IDLE;
      end
      S_MEM_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_hit  = 1'b1;
        cmd.gsel     = GSEL_MEM;
        state_nxt    = S_IDLE;
      end
      S_PAIR_CHK: begin
        if (st.pair_empty) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          cmd.gsel     = GSEL_REPL;
          state_nxt    = S_IDLE;
        end else begin
          cmd.pair_probe = 1'b1;
          cmd.mem_rd     = 1'b1;
          cmd.asel       = ASEL_KEY;
          state_nxt      = S_PAIR_KEY;
        end
      end
      S_PAIR_KEY: begin
        if (st.key_eq) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = ASEL_VAL;
          state_nxt  = S_MEM_OUT;
        end else begin
          cmd.pair_lt = st.key_lt;
          cmd.pair_gt = !st.key_lt;
          state_nxt   = S_PAIR_CHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/fcg_dp.sv */
`default_nettype none
module fcg_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fcg_pkg::in_word_t                 in_word,
  input  wire logic                              cfg_we,
  input  wire logic [fcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fcg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire fcg_pkg::cmd_t                     cmd,
  output fcg_pkg::status_t                       st,
  output logic                                   out_valid,
  output fcg_pkg::out_word_t                     out_word
);
  import fcg_pkg::*;

  localparam int PW = 14;

  logic [15:0]       repl_r;
  logic [3:0]        maps_r;
  logic [1:0]        mode_r  [MAX_MAPS];
  logic [15:0]       first_r [MAX_MAPS];
  logic [15:0]       last_r  [MAX_MAPS];
  logic [11:0]       count_r [MAX_MAPS];
  logic [11:0]       base_r  [MAX_MAPS];
  logic [15:0]       mem     [TABLE_DEPTH];
  logic [15:0]       rd_r;
  logic [15:0]       code_r;
  logic [SCNT_W-1:0] scan_r;
  logic signed [PW-1:0] lo_r, hi_r;
  logic [11:0]       mid_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [SIDX_W-1:0] s;
  logic [15:0]       offs;
  logic [16:0]       addr_full;
  logic [TADDR_W-1:0] rd_addr;
  logic signed [PW:0] mid_sum;
  logic [11:0]       mid;
  logic [7:0]        lead, trail;
  logic [15:0]       sj_idx, sj_row, sj_part;
  logic [15:0]       glyph_sel;
  logic [31:0]       n_scan;

  assign s     = scan_r[SIDX_W-1:0];
  assign offs  = code_r - first_r[s];
  assign mid_sum = {lo_r[PW-1], lo_r} + {hi_r[PW-1], hi_r};
  assign mid   = mid_sum[12:1];

  always_comb begin
    case (cmd.asel)
      ASEL_BASE: addr_full = {5'd0, base_r[s]};
      ASEL_TAB:  addr_full = {5'd0, base_r[s]} + {1'b0, offs};
      ASEL_KEY:  addr_full = {5'd0, base_r[s]} + {4'd0, mid, 1'b0};
      default:   addr_full = {5'd0, base_r[s]} + {4'd0, mid_r, 1'b1};
    endcase
  end
  assign rd_addr = addr_full[TADDR_W-1:0];

  assign lead    = code_r[15:8];
  assign trail   = code_r[7:0];
  assign sj_idx  = {8'd0, trail} - (trail[7] ? 16'd65 : 16'd64);
  assign sj_row  = ({8'd0, lead} - 16'd136) * 16'd188;
  assign sj_part = sj_row + sj_idx;

  always_comb begin
    case (cmd.gsel)
      GSEL_LINEAR: glyph_sel = offs;
      GSEL_SJ_FIX: glyph_sel = sj_part + 16'd702;
      GSEL_SJ_TAB: glyph_sel = sj_part - 16'd94 + rd_r;
      GSEL_MEM:    glyph_sel = rd_r;
      default:     glyph_sel = repl_r;
    endcase
  end

  assign n_scan = (32'(maps_r) > MAX_MAPS) ? MAX_MAPS : 32'(maps_r);

  assign st.scan_end   = (32'(scan_r) >= n_scan);
  assign st.in_range   = (code_r >= first_r[s]) && (code_r <= last_r[s]);
  assign st.mode       = mode_r[s];
  assign st.count_zero = (count_r[s] == 12'd0);
  assign st.pair_empty = (hi_r < lo_r);
  assign st.key_eq     = (code_r == rd_r);
  assign st.key_lt     = (code_r < rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= '0;
      maps_r <= '0;
      for (int i = 0; i < MAX_MAPS; i++) begin
        mode_r[i]  <= '0;
        first_r[i] <= '0;
        last_r[i]  <= '0;
        count_r[i] <= '0;
        base_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_REPLACEMENT) repl_r <= cfg_wdata[15:0];
        if (cfg_index == REG_MAPS_IN_USE) maps_r <= cfg_wdata[3:0];
      end
      if (cmd.desc_wr && (32'(in_word.slot) < MAX_MAPS)) begin
        mode_r[in_word.slot[SIDX_W-1:0]]  <= in_word.map_mode;
        first_r[in_word.slot[SIDX_W-1:0]] <= in_word.first_code;
        last_r[in_word.slot[SIDX_W-1:0]]  <= in_word.last_code;
        count_r[in_word.slot[SIDX_W-1:0]] <= in_word.entry_count;
        base_r[in_word.slot[SIDX_W-1:0]]  <= in_word.table_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tab_wr) begin
      mem[TADDR_W'({4'd0, in_word.word_address})] <= in_word.word_value;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_start) begin
      code_r <= in_word.code;
      scan_r <= '0;
    end else if (cmd.scan_next) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.pair_init) begin
      lo_r <= '0;
      hi_r <= $signed({2'b00, count_r[s]}) - PW'(1);
    end else if (cmd.pair_lt) begin
      hi_r <= $signed({2'b00, mid_r}) - PW'(1);
    end else if (cmd.pair_gt) begin
      lo_r <= $signed({2'b00, mid_r}) + PW'(1);
    end
    if (cmd.pair_probe) mid_r <= mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
    if (cmd.out_load) begin
      out_word_r.glyph     <= glyph_sel;
      out_word_r.range_hit <= cmd.out_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

/* rtl/core/font_code_to_glyph_mapper.sv */
// Lookup: the controller scans the slots in order until one matches (linear, fixed Shift-JIS),
// or returns the replacement glyph when none of the scanned slots does; modes that read a
// table word add that read, and pairs mode adds a key read per binary-search probe and a
// value read. The strobe follows the last busy cycle, when the next word can be accepted.
// Descriptor and table-word writes are done in the accept cycle; busy stays low.
// Synchronous reset clears config registers, descriptors, controller state and the strobe; table memory is not cleared.
`default_nettype none
module font_code_to_glyph_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire fcg_pkg::in_word_t              in_word,
  output logic                                out_valid,
  output fcg_pkg::out_word_t                  out_word,
  input  wire logic                           cfg_we,
  input  wire logic [fcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fcg_pkg::*;

  cmd_t    cmd;
  status_t st;

  fcg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_word.kind),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  fcg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
  import fcg_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int SCENES = 8;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [1:0]  slot_mode  [MAX_MAPS];
  logic [15:0] slot_first [MAX_MAPS];
  logic [15:0] slot_last  [MAX_MAPS];
  logic [11:0] slot_count [MAX_MAPS];
  logic [11:0] slot_base  [MAX_MAPS];
  logic [15:0] glyph_mem  [TABLE_DEPTH];
  bit          glyph_set  [TABLE_DEPTH];
  logic [15:0] repl_glyph;
  logic [3:0]  maps_used;

  out_word_t glyph_q[$];
  out_word_t want;
  int idle_pct = 10;
  int n_fail = 0;
  int n_lookups = 0;
  int n_descs = 0;
  int n_words = 0;
  int n_regs = 0;
  int quiet = 0;
  int miss_addr = -1;

  font_code_to_glyph_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] mem_at(int unsigned addr);
    if (!glyph_set[addr % TABLE_DEPTH] && miss_addr < 0) begin
      miss_addr = int'(addr % TABLE_DEPTH);
    end
    return glyph_mem[addr % TABLE_DEPTH];
  endfunction

  function automatic out_word_t predict_glyph(logic [15:0] c);
    out_word_t r;
    logic [15:0] lead, trail, idx, key, g;
    int n, s, lo, hi, mid;
    bit found;
    r.glyph = repl_glyph;
    r.range_hit = 1'b0;
    n = (maps_used > MAX_MAPS) ? MAX_MAPS : int'(maps_used);
    lead = {8'h00, c[15:8]};
    trail = {8'h00, c[7:0]};
    for (s = 0; s < n && !r.range_hit; s++) begin
      if (c >= slot_first[s] && c <= slot_last[s]) begin
        r.range_hit = 1'b1;
        g = repl_glyph;
        case (slot_mode[s])
          MODE_LINEAR: begin
            g = c - slot_first[s];
          end
          MODE_SJIS: begin
            idx = (trail >= 16'h0080) ? trail - 16'd65 : trail - 16'd64;
            g = (lead - 16'd136) * 16'd188 + idx;
            if (slot_count[s] == 12'd0) begin
              g = g + 16'd702;
            end else begin
              g = g - 16'd94 + mem_at(slot_base[s]);
            end
          end
          MODE_TABLE: begin
            g = mem_at(slot_base[s] + (c - slot_first[s]));
          end
          default: begin
            lo = 0;
            hi = int'(slot_count[s]) - 1;
            found = 1'b0;
            while (!found && hi >= lo) begin
              mid = (lo + hi) / 2;
              key = mem_at(slot_base[s] + 2 * mid);
              if (c == key) begin
                g = mem_at(slot_base[s] + 2 * mid + 1);
                found = 1'b1;
              end else if (c < key) begin
                hi = mid - 1;
              end else begin
                lo = mid + 1;
              end
            end
          end
        endcase
        r.glyph = g;
      end
    end
    return r;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.kind = 2'($urandom_range(3));
    w.slot = 3'($urandom_range(7));
    w.map_mode = 2'($urandom_range(3));
    w.first_code = 16'($urandom);
    w.last_code = 16'($urandom);
    w.entry_count = 12'($urandom_range(2048));
    w.table_base = 12'($urandom);
    w.word_address = 12'($urandom);
    w.word_value = 16'($urandom);
    w.code = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t desc_word(logic [2:0] s, logic [1:0] mode, logic [15:0] first,
                                         logic [15:0] last, logic [11:0] count,
                                         logic [11:0] base);
    in_word_t w;
    w = rand_word();
    w.kind = KIND_DESC;
    w.slot = s;
    w.map_mode = mode;
    w.first_code = first;
    w.last_code = last;
    w.entry_count = count;
    w.table_base = base;
    return w;
  endfunction

  function automatic in_word_t table_word(logic [11:0] addr, logic [15:0] value);
    in_word_t w;
    w = rand_word();
    w.kind = KIND_WORD;
    w.word_address = addr;
    w.word_value = value;
    return w;
  endfunction

  function automatic in_word_t lookup_word(logic [15:0] c);
    in_word_t w;
    w = rand_word();
    w.kind = KIND_LOOKUP;
    w.code = c;
    return w;
  endfunction

  // start stays high from one accept into the next word unless a gap is taken
  task automatic put_word(in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(15) == 0) gap = gap + $urandom_range(SETTLE);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    case (w.kind)
      KIND_DESC: begin
        slot_mode[w.slot] = w.map_mode;
        slot_first[w.slot] = w.first_code;
        slot_last[w.slot] = w.last_code;
        slot_count[w.slot] = w.entry_count;
        slot_base[w.slot] = w.table_base;
        n_descs++;
      end
      KIND_WORD: begin
        glyph_mem[w.word_address] = w.word_value;
        glyph_set[w.word_address] = 1'b1;
        n_words++;
      end
      KIND_LOOKUP: begin
        glyph_q.push_back(predict_glyph(w.code));
        n_lookups++;
      end
      default: ;
    endcase
  endtask

  // table words that a lookup would read are given a value before the lookup
  task automatic send_word(in_word_t w);
    if (w.kind == KIND_LOOKUP) begin
      do begin
        miss_addr = -1;
        void'(predict_glyph(w.code));
        if (miss_addr >= 0) put_word(table_word(12'(miss_addr), 16'($urandom)));
      end while (miss_addr >= 0);
    end
    put_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_REPLACEMENT: repl_glyph = data[15:0];
      REG_MAPS_IN_USE: maps_used = data[3:0];
      default: ;
    endcase
    n_regs++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] repl, logic [3:0] maps);
    drain();
    write_reg(REG_REPLACEMENT, repl);
    write_reg(REG_MAPS_IN_USE, {12'($urandom), maps});
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    end
  endtask

  task automatic test_reset_state();
    send_word(lookup_word(16'h1234));
    send_word(lookup_word(16'h0000));
    set_config(16'h0000, 4'd8);
    send_word(lookup_word(16'h0000));
    send_word(lookup_word(16'hFFFF));
  endtask

  task automatic test_directed();
    set_config(16'hFFFF, 4'd15);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0005);
    send_word(desc_word(3'd0, MODE_LINEAR, 16'h0100, 16'h01FF, 12'd0, 12'd0));
    send_word(desc_word(3'd1, MODE_LINEAR, 16'h3000, 16'h2000, 12'd0, 12'd0));
    send_word(desc_word(3'd2, MODE_SJIS, 16'h8140, 16'h9FFC, 12'd0, 12'd0));
    send_word(desc_word(3'd3, MODE_SJIS, 16'hE040, 16'hEAFF, 12'h800, 12'hFFF));
    send_word(desc_word(3'd4, MODE_TABLE, 16'h4000, 16'h40FF, 12'd0, 12'hFF0));
    send_word(desc_word(3'd5, MODE_PAIRS, 16'h5000, 16'h50FF, 12'd0, 12'd0));
    send_word(desc_word(3'd6, MODE_PAIRS, 16'h6000, 16'h60FF, 12'd3, 12'hFFC));
    send_word(desc_word(3'd7, MODE_LINEAR, 16'h0000, 16'hFFFF, 12'd0, 12'd0));
    // pair list wraps past the top of table memory
    send_word(table_word(12'hFFC, 16'h6010));
    send_word(table_word(12'hFFD, 16'h0A01));
    send_word(table_word(12'hFFE, 16'h6020));
    send_word(table_word(12'hFFF, 16'h0A02));
    send_word(table_word(12'h000, 16'h6030));
    send_word(table_word(12'h001, 16'h0A03));
    send_word(lookup_word(16'h01FF));
    send_word(lookup_word(16'h0100));
    send_word(lookup_word(16'h2800));
    send_word(lookup_word(16'h8140));
    send_word(lookup_word(16'h9F80));
    send_word(lookup_word(16'hE5A0));
    send_word(lookup_word(16'h40FF));
    send_word(lookup_word(16'h5010));
    send_word(lookup_word(16'h6010));
    send_word(lookup_word(16'h6030));
    send_word(lookup_word(16'h6025));
    send_word(lookup_word(16'hFFFF));
    begin
      in_word_t w;
      w = rand_word();
      w.kind = KIND_NONE;
      send_word(w);
    end
    set_config(16'h0000, 4'd0);
    send_word(lookup_word(16'h0100));
  endtask

  task automatic run_scene();
    logic [15:0] repl, first, last, c;
    logic [11:0] count, base;
    logic [3:0] maps;
    logic [2:0] s;
    logic [1:0] mode;
    int k;
    case ($urandom_range(3))
      0: repl = 16'h0000;
      1: repl = 16'hFFFF;
      default: repl = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0: maps = 4'd0;
      1: maps = 4'd8;
      2: maps = 4'd15;
      default: maps = 4'($urandom_range(15, 1));
    endcase
    set_config(repl, maps);
    repeat ($urandom_range(8, 1)) begin
      s = 3'($urandom_range(7));
      mode = 2'($urandom_range(3));
      first = 16'($urandom);
      case ($urandom_range(9))
        0: begin
          first = 16'h0000;
          last = 16'hFFFF;
        end
        1: begin
          if (first == 16'h0000) first = 16'h0001;
          last = 16'($urandom_range(first - 1));
        end
        2: last = first;
        default: begin
          k = first + $urandom_range(255);
          last = (k > 65535) ? 16'hFFFF : 16'(k);
        end
      endcase
      base = 12'($urandom);
      case (mode)
        MODE_SJIS: count = $urandom_range(1) ? 12'd0 : 12'($urandom_range(2048, 1));
        MODE_PAIRS: begin
          case ($urandom_range(7))
            0: count = 12'd0;
            1: count = 12'($urandom_range(2048, 13));
            default: count = 12'($urandom_range(12, 1));
          endcase
        end
        default: count = 12'($urandom_range(2048));
      endcase
      send_word(desc_word(s, mode, first, last, count, base));
      if (mode == MODE_PAIRS && count <= 12) begin
        k = first + $urandom_range(3);
        for (int i = 0; i < count; i++) begin
          send_word(table_word(12'(base + 2 * i), (k > 65535) ? 16'hFFFF : 16'(k)));
          send_word(table_word(12'(base + 2 * i + 1), 16'($urandom)));
          k = k + $urandom_range(6, 1);
        end
      end
    end
    repeat ($urandom_range(40, 20)) begin
      s = 3'($urandom_range(7));
      case ($urandom_range(19))
        0: send_word(rand_word());
        1: send_word(table_word(12'($urandom), 16'($urandom)));
        default: begin
          case ($urandom_range(9))
            0: c = 16'($urandom);
            1: c = slot_first[s];
            2: c = slot_last[s];
            default: begin
              if (slot_mode[s] == MODE_PAIRS && slot_count[s] != 12'd0
                  && $urandom_range(2) != 0) begin
                c = mem_at(slot_base[s] + 2 * $urandom_range(slot_count[s] - 1));
              end else if (slot_first[s] <= slot_last[s]) begin
                c = 16'($urandom_range(slot_last[s], slot_first[s]));
              end else begin
                c = 16'($urandom);
              end
            end
          endcase
          send_word(lookup_word(c));
        end
      endcase
    end
  endtask

  task automatic run_phase(int pct);
    idle_pct = pct;
    repeat (SCENES) run_scene();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (glyph_q.size() == 0) begin
        $error("result with no lookup pending: glyph %h range_hit %b",
               out_word.glyph, out_word.range_hit);
        n_fail++;
      end else begin
        want = glyph_q.pop_front();
        if (out_word.glyph !== want.glyph) begin
          $error("glyph: expected %h, actual %h", want.glyph, out_word.glyph);
          n_fail++;
        end
        if (out_word.range_hit !== want.range_hit) begin
          $error("range_hit: expected %b, actual %b", want.range_hit, out_word.range_hit);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("font_code_to_glyph_mapper: mismatch");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_MAPS; i++) begin
      slot_mode[i] = MODE_LINEAR;
      slot_first[i] = '0;
      slot_last[i] = '0;
      slot_count[i] = '0;
      slot_base[i] = '0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      glyph_mem[i] = '0;
      glyph_set[i] = 1'b0;
    end
    repl_glyph = '0;
    maps_used = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    run_phase(10);
    run_phase(57);
    run_phase(0);
    drain();
    $display("covered %0d lookups, %0d descriptor writes, %0d table writes, %0d register writes",
             n_lookups, n_descs, n_words, n_regs);
    $display("all four map modes, 0 to 15 maps in use, sender gaps at 10%%, 57%% and none");
    if (n_fail == 0 && glyph_q.size() == 0) begin
      $display("font_code_to_glyph_mapper: match");
    end else begin
      $display("font_code_to_glyph_mapper: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
